/* hdl/slc_pkg.sv */
// types, constants and codes shared by the label compactor modules
// no dependencies
`default_nettype none
package slc_pkg;

	localparam int LabelBits = 16;
	localparam int LabelW = 16;
	localparam int IdW = 16;
	localparam logic [IdW-1:0] IdMax = {IdW{1'b1}};

	typedef enum logic [1:0] {
		KIND_VOXEL = 2'd0,
		KIND_PAIR  = 2'd1,
		KIND_CLEAR = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_EMIT
	} state_t;

	typedef struct packed {
		kind_t             kind;
		logic [LabelW-1:0] label;
	} in_t;

	typedef struct packed {
		logic [IdW-1:0] new_label;
		logic [IdW-1:0] labels_used;
	} out_t;

	typedef struct packed {
		logic in_ready;
		logic capture;
		logic clear_start;
		logic clear_step;
		logic lookup;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic slot_free;
	} sts_t;

endpackage
`default_nettype wire

/* hdl/slc_ctrl.sv */
// controller state machine of the label compactor
// depends on slc_pkg
`default_nettype none
module slc_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire slc_pkg::kind_t in_kind,
	input  wire slc_pkg::sts_t  sts,
	output slc_pkg::cmd_t      cmd
);

	slc_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= slc_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			slc_pkg::ST_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (sts.clear_last) begin
					state_d = slc_pkg::ST_IDLE;
				end
			end
			slc_pkg::ST_IDLE: begin
				cmd.in_ready = 1'b1;
				if (in_valid) begin
					unique case (in_kind)
						slc_pkg::KIND_VOXEL, slc_pkg::KIND_PAIR: begin
							cmd.capture = 1'b1;
							state_d = slc_pkg::ST_LOOKUP;
						end
						slc_pkg::KIND_CLEAR: begin
							cmd.clear_start = 1'b1;
							state_d = slc_pkg::ST_CLEAR;
						end
						default: begin
							state_d = slc_pkg::ST_IDLE;
						end
					endcase
				end
			end
			slc_pkg::ST_LOOKUP: begin
				cmd.lookup = 1'b1;
				state_d = slc_pkg::ST_EMIT;
			end
			slc_pkg::ST_EMIT: begin
				cmd.emit = sts.slot_free;
				if (sts.slot_free) begin
					state_d = slc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = slc_pkg::ST_CLEAR;
			end
		endcase
	end

endmodule
`default_nettype wire

/* hdl/slc_datapath.sv */
// map memory, id counter, clear sweep and output register
// depends on slc_pkg
`default_nettype none
module slc_datapath #(
	parameter int LABEL_BITS = slc_pkg::LabelBits
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire slc_pkg::in_t  in_data,
	input  wire slc_pkg::cmd_t cmd,
	input  wire logic     out_ready,
	output slc_pkg::sts_t sts,
	output logic          out_valid,
	output slc_pkg::out_t out_data
);

	localparam int Depth = 2 ** LABEL_BITS;
	localparam int IdW = slc_pkg::IdW;

	logic [IdW-1:0] mem [Depth];

	logic [LABEL_BITS-1:0] rd_addr;
	logic [LABEL_BITS-1:0] lab_q;
	slc_pkg::kind_t        kind_q;
	logic [IdW-1:0]        rd_q;
	logic [IdW-1:0]        cnt_q;
	logic [LABEL_BITS-1:0] clr_addr_q;
	slc_pkg::out_t         res_q;
	slc_pkg::out_t         out_q;
	logic                  out_valid_q;

	logic                  assign_new;
	logic [IdW-1:0]        cnt_inc;
	logic [IdW-1:0]        id;
	logic [IdW-1:0]        cnt_next;
	logic                  wr_en;
	logic [LABEL_BITS-1:0] wr_addr;
	logic [IdW-1:0]        wr_data;

	// upper label bits dropped, so labels alias modulo the map depth
	assign rd_addr = LABEL_BITS'(in_data.label);

	assign cnt_inc = cnt_q + IdW'(1);
	assign assign_new = (|lab_q) && (kind_q == slc_pkg::KIND_VOXEL)
		&& (rd_q == '0) && (cnt_q != slc_pkg::IdMax);
	assign id = !(|lab_q) ? '0 : (assign_new ? cnt_inc : rd_q);
	assign cnt_next = assign_new ? cnt_inc : cnt_q;

	always_comb begin
		wr_en = 1'b0;
		wr_addr = clr_addr_q;
		wr_data = '0;
		if (cmd.clear_step) begin
			wr_en = 1'b1;
		end else if (cmd.lookup && assign_new) begin
			wr_en = 1'b1;
			wr_addr = lab_q;
			wr_data = cnt_inc;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			lab_q <= rd_addr;
			kind_q <= in_data.kind;
		end
		if (cmd.lookup) begin
			res_q.new_label <= id;
			res_q.labels_used <= cnt_next;
		end
		if (cmd.emit) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			clr_addr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear_start) begin
				cnt_q <= '0;
				clr_addr_q <= '0;
			end else if (cmd.clear_step) begin
				clr_addr_q <= clr_addr_q + LABEL_BITS'(1);
			end else if (cmd.lookup) begin
				cnt_q <= cnt_next;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.clear_last = &clr_addr_q;
	assign sts.slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule
`default_nettype wire

/* hdl/sequential_label_compactor.sv */
// label compactor top: voxel/pair word in, compacted id word out
// voxel or pair word: captured with the map read, then looked up, then loaded into the output register once it is free
// a new word is accepted only after the previous result has been loaded into the output register
// clear word: no result, sweeps the map one entry a cycle and resets the id counter
// reset: async active low, then the same map sweep before in_ready
`default_nettype none
module sequential_label_compactor #(
	parameter int LABEL_BITS = slc_pkg::LabelBits
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire slc_pkg::in_t in_data,
	output logic          out_valid,
	input  wire logic     out_ready,
	output slc_pkg::out_t out_data
);

	slc_pkg::cmd_t cmd;
	slc_pkg::sts_t sts;

	slc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_kind  (in_data.kind),
		.sts      (sts),
		.cmd      (cmd)
	);

	slc_datapath #(
		.LABEL_BITS (LABEL_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.out_ready (out_ready),
		.sts       (sts),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

	assign in_ready = cmd.in_ready;

	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_data.kind == slc_pkg::KIND_CLEAR) |=> !in_ready)
		else $error("input taken right after a clear word");

	a_lookup_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (in_data.kind == slc_pkg::KIND_VOXEL ||
		in_data.kind == slc_pkg::KIND_PAIR)) |=> (cmd.lookup && !in_ready))
		else $error("map lookup did not follow an accepted word");

	a_id_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.new_label <= out_data.labels_used))
		else $error("compacted id above number of labels used");

endmodule
`default_nettype wire
